@@ hw/rtl/bil_pkg.sv @@
package bil_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int WORD_BITS  = 32;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_SELECT  = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_REPLACE = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REPORT
  } ctl_state_t;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         index;
    logic signed [31:0] value;
  } in_req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic [4:0]         found_index;
    logic [4:0]         count;
    logic               is_empty;
    logic               is_full;
  } out_rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
    logic report;
  } dp_cmd_t;

endpackage

@@ hw/rtl/bounded_indexed_list_engine_core.sv @@
// Channel   Ports                      Transaction taken when
// input     start, busy, in_req        rising edge with start high and busy low
// result    out_valid, out_rsp         rising edge ending the cycle out_valid is high
//
// The result strobe is raised in the report state that follows the execute state:
// the execute state registers the shifting cell array and the parallel compare,
// then in the report state the priority encoder reports the first match. Busy
// stays high until the result cycle ends, so a new transaction is not taken
// before the last one's result has been reported. Synchronous active-low reset
// empties the list and needs no clearing pass; the receiver cannot stall the result.
module bounded_indexed_list_engine_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bil_pkg::in_req_t  in_req,
  output logic              out_valid,
  output bil_pkg::out_rsp_t out_rsp
);

  bil_pkg::dp_cmd_t cmd;

  bil_ctl u_ctl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  bil_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  assign out_valid = cmd.report;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after an accepted transaction");

  a_result_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("result strobe missing two cycles after acceptance");

  a_single_strobe : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.count <= 5'(bil_pkg::LIST_DEPTH)))
    else $error("entry count exceeds list depth");

endmodule

@@ hw/rtl/bil_ctl.sv @@
module bil_ctl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  output bil_pkg::dp_cmd_t cmd
);

  bil_pkg::ctl_state_t state_r;
  bil_pkg::ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bil_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bil_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = bil_pkg::ST_EXEC;
        end
      end
      bil_pkg::ST_EXEC: begin
        state_nxt = bil_pkg::ST_REPORT;
      end
      bil_pkg::ST_REPORT: begin
        state_nxt = bil_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bil_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    cmd.report  = 1'b0;
    case (state_r)
      bil_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      bil_pkg::ST_EXEC: begin
        cmd.execute = 1'b1;
      end
      bil_pkg::ST_REPORT: begin
        cmd.report = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/bil_dp.sv @@
module bil_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bil_pkg::dp_cmd_t  cmd,
  input  bil_pkg::in_req_t  in_req,
  output bil_pkg::out_rsp_t out_rsp
);

  bil_pkg::in_req_t               req_r;
  bil_pkg::word_t                 cell_r [bil_pkg::LIST_DEPTH];
  bil_pkg::word_t                 cell_nxt [bil_pkg::LIST_DEPTH];
  logic [bil_pkg::CNT_W-1:0]      count_r;
  logic [bil_pkg::CNT_W-1:0]      count_nxt;
  logic [bil_pkg::LIST_DEPTH-1:0] match_r;
  logic [bil_pkg::LIST_DEPTH-1:0] match_nxt;
  bil_pkg::word_t                 rd_r;
  bil_pkg::word_t                 rd_nxt;
  logic                           ok_r;
  logic                           ok_nxt;

  bil_pkg::word_t                 word;
  logic [5:0]                     cnt6;
  logic                           in_rng;
  logic [bil_pkg::CNT_W-1:0]      last;
  logic [bil_pkg::IDX_W-1:0]      rd_addr;
  logic [4:0]                     first_hit;

  assign word    = bil_pkg::word_t'(req_r.value);
  assign cnt6    = 6'(count_r);
  assign in_rng  = req_r.index < cnt6;
  assign last    = count_r - bil_pkg::CNT_W'(1);
  assign rd_addr = in_rng ? req_r.index[bil_pkg::IDX_W-1:0] : last[bil_pkg::IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.execute) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < bil_pkg::LIST_DEPTH; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
      match_r <= match_nxt;
      rd_r    <= rd_nxt;
      ok_r    <= ok_nxt;
    end
  end

  always_comb begin
    count_nxt = count_r;
    ok_nxt    = 1'b0;
    rd_nxt    = '0;
    for (int i = 0; i < bil_pkg::LIST_DEPTH; i++) begin
      cell_nxt[i]  = cell_r[i];
      match_nxt[i] = (cell_r[i] == word) && (6'(i) < cnt6);
    end
    case (req_r.operation)
      bil_pkg::OP_INSERT: begin
        if ((count_r < bil_pkg::CNT_W'(bil_pkg::LIST_DEPTH)) && (req_r.index <= cnt6)) begin
          for (int i = 0; i < bil_pkg::LIST_DEPTH; i++) begin
            if (6'(i) == req_r.index) begin
              cell_nxt[i] = word;
            end else if ((i > 0) && (6'(i) > req_r.index)) begin
              cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
            end
          end
          count_nxt = count_r + bil_pkg::CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      bil_pkg::OP_REMOVE: begin
        if (in_rng) begin
          for (int i = 0; i < bil_pkg::LIST_DEPTH - 1; i++) begin
            if (6'(i) >= req_r.index) begin
              cell_nxt[i] = cell_r[i + 1];
            end
          end
          count_nxt = last;
          ok_nxt    = 1'b1;
        end
      end
      bil_pkg::OP_SELECT: begin
        ok_nxt = in_rng;
        if (count_r != '0) begin
          rd_nxt = cell_r[rd_addr];
        end
      end
      bil_pkg::OP_REPLACE: begin
        if (in_rng) begin
          cell_nxt[rd_addr] = word;
          ok_nxt            = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_comb begin
    first_hit = 5'(count_r);
    for (int i = bil_pkg::LIST_DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        first_hit = 5'(i);
      end
    end
  end

  always_comb begin
    out_rsp.ok          = ok_r;
    out_rsp.read_value  = 32'(rd_r);
    out_rsp.found_index = '0;
    out_rsp.count       = 5'(count_r);
    out_rsp.is_empty    = count_r == '0;
    out_rsp.is_full     = count_r == bil_pkg::CNT_W'(bil_pkg::LIST_DEPTH);
    if (cmd.report && (req_r.operation == bil_pkg::OP_SEARCH)) begin
      out_rsp.ok          = |match_r;
      out_rsp.found_index = first_hit;
    end
  end

endmodule

@@ bench/list_result_checker.sv @@
`timescale 1ns / 100ps
module list_result_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  bil_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  bil_pkg::out_rsp_t out_rsp,
  output int                fail_count,
  output int                outstanding,
  output int                checked
);
  import bil_pkg::*;

  word_t    shadow_words [LIST_DEPTH];
  int       shadow_len = 0;
  out_rsp_t predicted_rsps [$];
  int       fails = 0;
  int       checks = 0;

  // Applies one request to the shadow list and returns the result it should produce.
  function automatic out_rsp_t apply_list_op(in_req_t req);
    out_rsp_t rsp;
    int       pos;
    bit       hit;
    rsp = '0;
    pos = int'(req.index);
    hit = 1'b0;
    case (req.operation)
      OP_INSERT: begin
        if (shadow_len < LIST_DEPTH && pos <= shadow_len) begin
          for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = req.value;
          shadow_len++;
          rsp.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos < shadow_len) begin
          for (int i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          rsp.ok = 1'b1;
        end
      end
      OP_SELECT: begin
        if (pos < shadow_len) begin
          rsp.read_value = shadow_words[pos];
          rsp.ok = 1'b1;
        end else if (shadow_len > 0) begin
          rsp.read_value = shadow_words[shadow_len-1];
        end
      end
      OP_SEARCH: begin
        rsp.found_index = 5'(shadow_len);
        for (int i = 0; i < shadow_len; i++) begin
          if (!hit && shadow_words[i] == req.value) begin
            hit = 1'b1;
            rsp.found_index = 5'(i);
          end
        end
        rsp.ok = hit;
      end
      OP_REPLACE: begin
        if (pos < shadow_len) begin
          shadow_words[pos] = req.value;
          rsp.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rsp.count    = 5'(shadow_len);
    rsp.is_empty = (shadow_len == 0);
    rsp.is_full  = (shadow_len == LIST_DEPTH);
    return rsp;
  endfunction

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      fails++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endtask

  always @(posedge clk) begin
    out_rsp_t want;
    if (!rst_n) begin
      shadow_len = 0;
      predicted_rsps.delete();
    end else begin
      if (out_valid) begin
        if (predicted_rsps.size() == 0) begin
          fails++;
          $error("result transaction arrived with no request outstanding");
        end else begin
          want = predicted_rsps.pop_front();
          checks++;
          compare_field("ok", want.ok, out_rsp.ok);
          compare_field("read_value", want.read_value, out_rsp.read_value);
          compare_field("found_index", want.found_index, out_rsp.found_index);
          compare_field("count", want.count, out_rsp.count);
          compare_field("is_empty", want.is_empty, out_rsp.is_empty);
          compare_field("is_full", want.is_full, out_rsp.is_full);
        end
      end
      if (start && !busy) predicted_rsps.push_back(apply_list_op(in_req));
    end
    fail_count  <= fails;
    outstanding <= predicted_rsps.size();
    checked     <= checks;
  end

endmodule

@@ bench/tb_bounded_indexed_list_engine_core.sv @@
`timescale 1ns / 100ps
module tb_bounded_indexed_list_engine_core;
  import bil_pkg::*;

  localparam int             IDLE_LIMIT     = 2000;
  localparam int             PHASES         = 16;
  localparam int             PHASE_ITEMS    = 100;
  localparam logic [2:0]     OP_RESERVED_LO = 3'd5;
  localparam logic [2:0]     OP_RESERVED_HI = 3'd7;
  localparam logic [31:0]    WORD_MIN       = 32'h8000_0000;
  localparam logic [31:0]    WORD_MAX       = 32'h7fff_ffff;
  localparam int             MODE_GROW      = 0;
  localparam int             MODE_SHRINK    = 1;
  localparam int             MODE_MIXED     = 2;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  logic     out_valid;
  in_req_t  in_req;
  out_rsp_t out_rsp;
  int       fail_count;
  int       outstanding;
  int       checked;
  int       sent = 0;
  int       quiet_cycles = 0;

  bounded_indexed_list_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  list_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(logic [2:0] op, logic [5:0] idx, logic [31:0] val);
    in_req_t req;
    req.operation = op;
    req.index     = idx;
    req.value     = val;
    in_req <= req;
    start  <= 1'b1;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic maybe_idle(bit allowed);
    if (allowed && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(int mode);
    int ins_pct;
    int rem_pct;
    int r;
    ins_pct = (mode == MODE_GROW) ? 55 : (mode == MODE_SHRINK) ? 10 : 25;
    rem_pct = (mode == MODE_GROW) ? 10 : (mode == MODE_SHRINK) ? 55 : 25;
    if ($urandom_range(0, 99) < 3) return 3'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
    r = $urandom_range(0, 99);
    if (r < ins_pct) return OP_INSERT;
    if (r < ins_pct + rem_pct) return OP_REMOVE;
    case ($urandom_range(0, 2))
      0:       return OP_SELECT;
      1:       return OP_SEARCH;
      default: return OP_REPLACE;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom;
    if (r < 70) return 32'($urandom_range(0, 7));
    case ($urandom_range(0, 3))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return 32'hffff_ffff;
      default: return 32'h0;
    endcase
  endfunction

  initial begin
    int mode;
    rst_n  = 1'b0;
    start  = 1'b0;
    in_req = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Corner cases on an empty list first, then a short list of extreme words.
    issue(OP_SELECT, 6'd0, 32'h0);
    issue(OP_REMOVE, 6'd0, 32'h0);
    issue(OP_SEARCH, 6'd0, 32'd5);
    issue(OP_REPLACE, 6'd0, 32'd9);
    issue(OP_INSERT, 6'd1, 32'd3);
    issue(OP_INSERT, 6'd0, WORD_MIN);
    issue(OP_INSERT, 6'd1, WORD_MAX);
    issue(OP_INSERT, 6'd0, 32'h0);
    issue(OP_INSERT, 6'd1, 32'hffff_ffff);
    issue(OP_INSERT, 6'd63, 32'd7);
    issue(OP_SELECT, 6'd63, 32'h0);
    issue(OP_SELECT, 6'd2, 32'h0);
    issue(OP_SEARCH, 6'd0, WORD_MAX);
    issue(OP_SEARCH, 6'd0, 32'd12345);
    issue(OP_REPLACE, 6'd0, 32'h5555_5555);
    issue(OP_REPLACE, 6'd63, 32'haaaa_aaaa);
    for (int c = OP_RESERVED_LO; c <= OP_RESERVED_HI; c++) issue(3'(c), 6'd1, 32'd1);
    issue(OP_REMOVE, 6'd3, 32'h0);
    issue(OP_REMOVE, 6'd0, 32'h0);
    issue(OP_REMOVE, 6'd40, 32'h0);
    issue(OP_SELECT, 6'd0, 32'h0);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      mode = (p % 3 == 0) ? MODE_GROW : (p % 3 == 1) ? MODE_MIXED : MODE_SHRINK;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue(pick_op(mode),
              ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 17)),
              pick_value());
        maybe_idle(p < 6 || p > 8);
      end
      if (p == 4 || p == 11) drain();
    end

    drain();
    repeat (8) @(posedge clk);
    $display("Issued %0d requests: empty and full list corners, then growth, shrink", sent);
    $display("and balanced random phases; %0d results compared field by field.", checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
